/* rtl/fatc_pkg.sv */
// Package for the fan timer controller: request, voice and report codes,
// configuration indexes and the structs shared by the datapath modules.
// No dependencies.
package fatc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SECONDS_PER_HOUR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOURS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LOW         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MEDIUM      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_HIGH        = 3'd5;

  localparam logic [15:0] RST_SECONDS_PER_HOUR = 16'd3600;
  localparam logic [7:0]  RST_MAX_HOURS        = 8'd24;
  localparam logic [7:0]  RST_PWM_PERIOD       = 8'd10;
  localparam logic [7:0]  RST_DUTY_LOW         = 8'd6;
  localparam logic [7:0]  RST_DUTY_MEDIUM      = 8'd8;
  localparam logic [7:0]  RST_DUTY_HIGH        = 8'd10;

  // Bit positions, shared by key samples and LED bits
  localparam int BIT_TIMER  = 0;
  localparam int BIT_FILTER = 1;
  localparam int BIT_POWER  = 2;
  localparam int BIT_FAN    = 3;

  localparam logic [3:0] LED_POWER_ONLY = 4'h4;

  typedef enum logic [2:0] {
    REQ_PWM    = 3'd0,
    REQ_SECOND = 3'd1,
    REQ_KEYS   = 3'd2,
    REQ_VOICE  = 3'd3,
    REQ_CLOUD  = 3'd4
  } req_kind_t;

  typedef enum logic [2:0] {
    VC_WAKE   = 3'd0,
    VC_ON     = 3'd1,
    VC_OFF    = 3'd2,
    VC_UP     = 3'd3,
    VC_DOWN   = 3'd4,
    VC_TIMER  = 3'd5,
    VC_FILTER = 3'd6,
    VC_IGNORE = 3'd7
  } voice_cmd_t;

  typedef enum logic [2:0] {
    REP_NONE      = 3'd0,
    REP_POWER     = 3'd1,
    REP_TIMER     = 3'd2,
    REP_INDICATOR = 3'd3,
    REP_FAN_LEVEL = 3'd4
  } rep_kind_t;

  typedef struct packed {
    logic [15:0] seconds_per_hour;
    logic [7:0]  max_hours;
    logic [7:0]  pwm_period;
    logic [7:0]  duty_low;
    logic [7:0]  duty_medium;
    logic [7:0]  duty_high;
  } cfg_t;

  typedef struct packed {
    logic        power;
    logic [3:0]  led;
    logic [1:0]  level;
    logic [7:0]  hours;
    logic [15:0] secs;
    logic [3:0]  prev_keys;
    logic [7:0]  phase;
    logic        pwm;
  } fan_state_t;

  typedef struct packed {
    rep_kind_t [2:0]  kind;
    logic [2:0][7:0]  val;
    logic [1:0]       n;
  } rep_set_t;

  // Everything one input item produces: state snapshot plus its report run
  typedef struct packed {
    logic [3:0]       led;
    logic [1:0]       level;
    logic [7:0]       hours;
    logic             fan_power;
    logic             pwm;
    rep_kind_t [2:0]  kind;
    logic [2:0][7:0]  val;
    logic [1:0]       count;
  } bundle_t;

  // Append one report; a full set drops further ones
  function automatic rep_set_t rep_push(rep_set_t r, rep_kind_t k, logic [7:0] v);
    rep_set_t o;
    o = r;
    case (r.n)
      2'd0: begin
        o.kind[0] = k;
        o.val[0]  = v;
        o.n       = 2'd1;
      end
      2'd1: begin
        o.kind[1] = k;
        o.val[1]  = v;
        o.n       = 2'd2;
      end
      2'd2: begin
        o.kind[2] = k;
        o.val[2]  = v;
        o.n       = 2'd3;
      end
      default: ;
    endcase
    return o;
  endfunction

endpackage

/* rtl/fatc_ifs.sv */
// Channel interfaces for the fan timer controller: request, result and
// configuration write. Depends on fatc_pkg for the configuration widths.
interface fatc_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [3:0] key_level;
  logic [2:0] voice_cmd;
  logic       cloud_power;
  logic [7:0] cloud_hours;
  logic [7:0] cloud_fan_level;
  logic       cloud_indicator;

  modport source (output valid, req_type, key_level, voice_cmd, cloud_power,
                  cloud_hours, cloud_fan_level, cloud_indicator, input ready);
  modport sink (input valid, req_type, key_level, voice_cmd, cloud_power,
                cloud_hours, cloud_fan_level, cloud_indicator, output ready);
endinterface

interface fatc_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] led_bits;
  logic [1:0] fan_level;
  logic [7:0] hours_left;
  logic       fan_power;
  logic       fan_pwm;
  logic [2:0] report_kind;
  logic [7:0] report_value;
  logic       last_result;

  modport source (output valid, led_bits, fan_level, hours_left, fan_power, fan_pwm,
                  report_kind, report_value, last_result, input ready);
  modport sink (input valid, led_bits, fan_level, hours_left, fan_power, fan_pwm,
                report_kind, report_value, last_result, output ready);
endinterface

interface fatc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fatc_pkg::CFG_IDX_W-1:0]  index;
  logic [fatc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/appliance_fan_timer_controller_unit.sv */
// Fan appliance controller: power, fan level, hour timer, filter LED, PWM.
// First result offered the cycle after the transfer into an empty queue.
// Throughput: one request per cycle while each yields one result taken at once;
// n reports from one request leave as n result transfers, and two waiting bundles stall requests.
// Reset (rst, synchronous, active high): state cleared, registers to defaults.
// Depends on fatc_pkg, fatc_ifs, fatc_regs, fatc_core and fatc_queue.
module appliance_fan_timer_controller_unit (
  input  logic     clk,
  input  logic     rst,
  fatc_cfg_if.sink cfg,
  fatc_req_if.sink req,
  fatc_res_if.source res
);
  import fatc_pkg::*;

  cfg_t    regs;
  bundle_t bundle;
  logic    q_full;
  logic    fire;

  // A request transfers whenever the queue has a free bundle slot,
  // independent of whether the current result is being taken.
  assign req.ready = !q_full;
  assign fire      = req.valid && req.ready;

  // Configuration: always ready, one write per transfer
  fatc_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // State update and report generation, all within the transfer cycle
  fatc_core u_core (
    .clk             (clk),
    .rst             (rst),
    .regs            (regs),
    .fire            (fire),
    .req_type        (req.req_type),
    .key_level       (req.key_level),
    .voice_cmd       (req.voice_cmd),
    .cloud_power     (req.cloud_power),
    .cloud_hours     (req.cloud_hours),
    .cloud_fan_level (req.cloud_fan_level),
    .cloud_indicator (req.cloud_indicator),
    .bundle          (bundle)
  );

  // Result bundles wait here and are split into result transfers
  fatc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (bundle),
    .full      (q_full),
    .res       (res)
  );

  // Empty result side means the queue has room
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res.valid |-> req.ready)
    else $error("request stalled with empty result queue");

  // Fan drive implies power LED and a nonzero level
  a_fan_power_state: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.fan_power |-> res.led_bits[BIT_POWER] && res.fan_level != 2'd0)
    else $error("fan driven while off or at level zero");

  // PWM high only while the fan is driven
  a_pwm_needs_power: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.fan_pwm |-> res.fan_power)
    else $error("PWM high with fan disabled");

  // A result carrying no report is always alone in its run
  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.report_kind == REP_NONE |-> res.last_result)
    else $error("empty report not marked last");

endmodule

/* rtl/fatc_regs.sv */
// Configuration register file for the fan timer controller.
// Depends on fatc_pkg and fatc_cfg_if.
module fatc_regs (
  input  logic          clk,
  input  logic          rst,
  fatc_cfg_if.sink      cfg,
  output fatc_pkg::cfg_t regs
);
  import fatc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.seconds_per_hour <= RST_SECONDS_PER_HOUR;
      regs.max_hours        <= RST_MAX_HOURS;
      regs.pwm_period       <= RST_PWM_PERIOD;
      regs.duty_low         <= RST_DUTY_LOW;
      regs.duty_medium      <= RST_DUTY_MEDIUM;
      regs.duty_high        <= RST_DUTY_HIGH;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SECONDS_PER_HOUR: regs.seconds_per_hour <= cfg.data;
        CFG_MAX_HOURS:        regs.max_hours        <= cfg.data[7:0];
        CFG_PWM_PERIOD:       regs.pwm_period       <= cfg.data[7:0];
        CFG_DUTY_LOW:         regs.duty_low         <= cfg.data[7:0];
        CFG_DUTY_MEDIUM:      regs.duty_medium      <= cfg.data[7:0];
        CFG_DUTY_HIGH:        regs.duty_high        <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/fatc_core.sv */
// Control state and next-state logic: one request in, new state and its
// report run out in the same cycle. Depends on fatc_pkg.
module fatc_core (
  input  logic              clk,
  input  logic              rst,
  input  fatc_pkg::cfg_t    regs,
  input  logic              fire,
  input  logic [2:0]        req_type,
  input  logic [3:0]        key_level,
  input  logic [2:0]        voice_cmd,
  input  logic              cloud_power,
  input  logic [7:0]        cloud_hours,
  input  logic [7:0]        cloud_fan_level,
  input  logic              cloud_indicator,
  output fatc_pkg::bundle_t bundle
);
  import fatc_pkg::*;

  fan_state_t st;
  fan_state_t st_next;
  rep_set_t   reps;

  function automatic fan_state_t go_on(fan_state_t s);
    fan_state_t o;
    o       = s;
    o.power = 1'b1;
    o.led   = LED_POWER_ONLY;
    o.level = 2'd0;
    o.hours = 8'd0;
    o.secs  = 16'd0;
    return o;
  endfunction

  function automatic fan_state_t go_off(fan_state_t s);
    fan_state_t o;
    o       = s;
    o.power = 1'b0;
    o.led   = 4'd0;
    o.level = 2'd0;
    o.hours = 8'd0;
    o.secs  = 16'd0;
    return o;
  endfunction

  // Step the hour setting, wrapping past the maximum
  function automatic fan_state_t timer_step(fan_state_t s, logic [7:0] max_h);
    fan_state_t o;
    o = s;
    if (s.hours < max_h) o.hours = s.hours + 8'd1;
    else o.hours = 8'd0;
    o.secs = 16'd0;
    o.led[BIT_TIMER] = (o.hours != 8'd0);
    return o;
  endfunction

  always_comb begin
    logic [3:0]  down;
    logic [15:0] sec_inc;
    logic [7:0]  hrs;
    logic [7:0]  duty;
    logic [7:0]  ph_inc;

    st_next = st;
    reps    = '0;
    down    = key_level & ~st.prev_keys;
    sec_inc = st.secs + 16'd1;
    hrs     = (cloud_hours > regs.max_hours) ? regs.max_hours : cloud_hours;
    ph_inc  = st.phase + 8'd1;
    case (st.level)
      2'd1:    duty = regs.duty_low;
      2'd2:    duty = regs.duty_medium;
      default: duty = regs.duty_high;
    endcase

    case (req_type)
      REQ_PWM: begin
        if (!(st.power && st.level != 2'd0)) begin
          st_next.phase = 8'd0;
          st_next.pwm   = 1'b0;
        end else begin
          st_next.pwm   = (st.phase < duty);
          st_next.phase = (ph_inc >= regs.pwm_period) ? 8'd0 : ph_inc;
        end
      end
      REQ_SECOND: begin
        if (st.hours != 8'd0) begin
          st_next.secs = sec_inc;
          if (sec_inc >= regs.seconds_per_hour) begin
            st_next.secs  = 16'd0;
            st_next.hours = st.hours - 8'd1;
            if (st.hours == 8'd1) begin
              st_next.power = 1'b0;
              st_next.led   = 4'd0;
              st_next.level = 2'd0;
              reps = rep_push(reps, REP_POWER, 8'd0);
              reps = rep_push(reps, REP_TIMER, 8'd0);
            end else begin
              reps = rep_push(reps, REP_TIMER, st.hours - 8'd1);
            end
          end
        end
      end
      REQ_KEYS: begin
        st_next.prev_keys = key_level;
        if (down[BIT_POWER]) begin
          if (st.power) begin
            st_next = go_off(st_next);
            reps = rep_push(reps, REP_POWER, 8'd0);
          end else begin
            st_next = go_on(st_next);
            reps = rep_push(reps, REP_POWER, 8'd1);
          end
        end else if (st.power) begin
          if (down[BIT_TIMER]) begin
            st_next = timer_step(st_next, regs.max_hours);
            reps = rep_push(reps, REP_TIMER, st_next.hours);
          end
          if (down[BIT_FILTER]) begin
            st_next.led[BIT_FILTER] = ~st_next.led[BIT_FILTER];
            reps = rep_push(reps, REP_INDICATOR, {7'd0, st_next.led[BIT_FILTER]});
          end
          if (down[BIT_FAN]) begin
            st_next.level = st_next.level + 2'd1;
            st_next.led[BIT_FAN] = (st_next.level != 2'd0);
            reps = rep_push(reps, REP_FAN_LEVEL, {6'd0, st_next.level});
          end
        end
      end
      REQ_VOICE: begin
        case (voice_cmd)
          VC_ON: begin
            if (!st.power) begin
              st_next = go_on(st);
              reps = rep_push(reps, REP_POWER, 8'd1);
            end
          end
          VC_OFF: begin
            st_next = go_off(st);
            reps = rep_push(reps, REP_POWER, 8'd0);
          end
          VC_UP: begin
            if (st.power) begin
              if (st.level != 2'd3) st_next.level = st.level + 2'd1;
              if (st_next.level != 2'd0) st_next.led[BIT_FAN] = 1'b1;
              reps = rep_push(reps, REP_FAN_LEVEL, {6'd0, st_next.level});
            end
          end
          VC_DOWN: begin
            if (st.power) begin
              if (st.level != 2'd0) st_next.level = st.level - 2'd1;
              if (st_next.level == 2'd0) st_next.led[BIT_FAN] = 1'b0;
              reps = rep_push(reps, REP_FAN_LEVEL, {6'd0, st_next.level});
            end
          end
          VC_TIMER: begin
            if (st.power) begin
              st_next = timer_step(st, regs.max_hours);
              reps = rep_push(reps, REP_TIMER, st_next.hours);
            end
          end
          VC_FILTER: begin
            if (st.power) begin
              st_next.led[BIT_FILTER] = ~st.led[BIT_FILTER];
              reps = rep_push(reps, REP_INDICATOR, {7'd0, st_next.led[BIT_FILTER]});
            end
          end
          default: ;
        endcase
      end
      REQ_CLOUD: begin
        if (cloud_power && !st.power) st_next = go_on(st);
        else if (!cloud_power && st.power) st_next = go_off(st);
        if (st_next.power) begin
          st_next.hours = hrs;
          st_next.secs  = 16'd0;
          st_next.led[BIT_TIMER] = (hrs != 8'd0);
          st_next.level = (cloud_fan_level > 8'd3) ? 2'd0 : cloud_fan_level[1:0];
          st_next.led[BIT_FAN]    = (st_next.level != 2'd0);
          st_next.led[BIT_FILTER] = cloud_indicator;
        end
      end
      default: ;
    endcase

    // PWM output is forced low whenever the fan is not driven
    if (!(st_next.power && st_next.level != 2'd0)) st_next.pwm = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  assign bundle.led       = st_next.led;
  assign bundle.level     = st_next.level;
  assign bundle.hours     = st_next.hours;
  assign bundle.fan_power = st_next.power && (st_next.level != 2'd0);
  assign bundle.pwm       = st_next.pwm;
  assign bundle.kind      = reps.kind;
  assign bundle.val       = reps.val;
  assign bundle.count     = (reps.n == 2'd0) ? 2'd1 : reps.n;

endmodule

/* rtl/fatc_queue.sv */
// Two-entry result queue that splits each stored bundle into its run of
// result transfers. Depends on fatc_pkg and fatc_res_if.
module fatc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fatc_pkg::bundle_t push_data,
  output logic              full,
  fatc_res_if.source        res
);
  import fatc_pkg::*;

  bundle_t    q [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic [1:0] sub;
  bundle_t    head;
  logic       last;
  logic       pop;

  assign head = q[rp];
  assign last = (sub == head.count - 2'd1);
  assign pop  = res.valid && res.ready && last;
  assign full = (fill == 2'd2);

  assign res.valid        = (fill != 2'd0);
  assign res.led_bits     = head.led;
  assign res.fan_level    = head.level;
  assign res.hours_left   = head.hours;
  assign res.fan_power    = head.fan_power;
  assign res.fan_pwm      = head.pwm;
  assign res.last_result  = last;

  always_comb begin
    case (sub)
      2'd1: begin
        res.report_kind  = head.kind[1];
        res.report_value = head.val[1];
      end
      2'd2: begin
        res.report_kind  = head.kind[2];
        res.report_value = head.val[2];
      end
      default: begin
        res.report_kind  = head.kind[0];
        res.report_value = head.val[0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
      sub  <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
      if (pop) sub <= 2'd0;
      else if (res.valid && res.ready) sub <= sub + 2'd1;
    end
  end

endmodule
